// ===== rtl/pfde_pkg.sv =====
`default_nettype none
package pfde_pkg;
  localparam int MAX_WIDTH_DEF = 128;
  localparam int MAX_PAGES_DEF = 8;
  localparam logic [7:0] WIDTH_RST = 8'd128;
  localparam logic [6:0] HEIGHT_RST = 7'd64;

  typedef enum logic [2:0] {
    ACT_ERASE = 3'd0,
    ACT_PIXEL = 3'd1,
    ACT_LINE  = 3'd2,
    ACT_FILL  = 3'd3,
    ACT_OUTL  = 3'd4,
    ACT_BLIT  = 3'd5,
    ACT_READ  = 3'd6,
    ACT_NONE  = 3'd7
  } action_t;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // pixel operation sent from the sequencer to the store unit
  typedef struct packed {
    logic        valid;
    logic        wr_byte;   // write whole byte (erase)
    logic        on;
    logic [10:0] x;         // signed, may be out of range
    logic [10:0] y;
    logic [7:0]  fill;
    logic [15:0] idx;       // byte index for erase
  } pix_op_t;
endpackage
`default_nettype wire

// ===== rtl/page_framebuffer_draw_engine.sv =====
`default_nettype none
// Monochrome page framebuffer drawing engine.
// Input channel: in_valid/in_stall carry one drawing action per transaction
// (erase, pixel, line, filled/outline rectangle, 8x8 blit, byte read).
// Output channel: out_valid/out_stall return one result per action with
// read_data and done_res.
// Config channel: cfg_valid/cfg_ready with cfg_index (0 width, 1 height)
// and cfg_data; write only while idle.
// A read passes through the T_RD and T_RD2 states, then raises out_valid.
// A drawing action issues one pixel per cycle from the cycle after
// acceptance and raises out_valid after the sequencer goes idle. A line
// adds one setup state per segment, and a steep line one hold step for each
// extra row it climbs within a column. Erase issues width*height/8 bytes,
// a large fill up to 255*255 pixels. The single read-modify-write port of
// the frame memory sets this rate. The next action can be taken in the
// cycle after the result transaction.
// After reset the memory is cleared by a pass over all MAX_WIDTH*MAX_PAGES
// bytes, during which no input is taken.
// A stalled result holds; the next action is not taken until it drains.
module page_framebuffer_draw_engine #(
  parameter int MAX_WIDTH = pfde_pkg::MAX_WIDTH_DEF,
  parameter int MAX_PAGES = pfde_pkg::MAX_PAGES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [2:0]        action,
  input  wire logic signed [8:0] x_a,
  input  wire logic signed [8:0] y_a,
  input  wire logic signed [8:0] x_b,
  input  wire logic signed [8:0] y_b,
  input  wire logic              pixel_value,
  input  wire logic [63:0]       pattern,
  input  wire logic [9:0]        byte_index,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             read_data,
  output logic                   done_res,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [7:0]        cfg_data
);
  typedef enum logic [4:0] {
    T_IDLE = 5'b00001, T_RUN = 5'b00010, T_DRAIN = 5'b00100,
    T_RD = 5'b01000, T_RD2 = 5'b10000
  } top_t;
  top_t st;
  logic [7:0] pw;
  logic [6:0] ph;
  logic [8:0] cols;
  logic [5:0] pages;
  logic [15:0] used16;
  logic        seq_busy, clr_busy, accept, rd_ok;
  logic [9:0]  ridx;
  logic [7:0]  rdat;
  pfde_pkg::pix_op_t op;

  assign cols = (pw > 8'(MAX_WIDTH - 1)) ? 9'(MAX_WIDTH) : {1'b0, pw};
  assign pages = (ph[6:3] > 4'(MAX_PAGES - 1)) ? 6'(MAX_PAGES) : {2'b0, ph[6:3]};
  assign used16 = 16'(cols) * 16'(pages);

  assign cfg_ready = 1'b1;
  assign in_stall = (st != T_IDLE) || out_valid || clr_busy;
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pw <= pfde_pkg::WIDTH_RST; ph <= pfde_pkg::HEIGHT_RST;
      st <= T_IDLE; out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_index == pfde_pkg::REG_WIDTH) pw <= cfg_data;
      if (cfg_valid && cfg_index == pfde_pkg::REG_HEIGHT) ph <= cfg_data[6:0];
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (st)
        T_IDLE: if (accept) begin
          read_data <= '0;
          done_res <= (action != pfde_pkg::ACT_NONE);
          ridx <= byte_index;
          rd_ok <= 16'(byte_index) < used16;
          if (action == pfde_pkg::ACT_READ) st <= T_RD;
          else st <= T_RUN;
        end
        T_RUN: if (!seq_busy) st <= T_DRAIN;
        T_DRAIN: begin st <= T_IDLE; out_valid <= 1'b1; end
        T_RD: st <= T_RD2;
        T_RD2: begin
          read_data <= rd_ok ? rdat : 8'h00;
          out_valid <= 1'b1; st <= T_IDLE;
        end
        default: st <= T_IDLE;
      endcase
    end
  end

  pfde_seq u_seq (
    .clk, .rst, .start(accept), .action, .x_a, .y_a, .x_b, .y_b,
    .pixel_value, .pattern, .used(used16),
    .op, .busy(seq_busy)
  );

  pfde_store #(.MAX_WIDTH(MAX_WIDTH), .MAX_PAGES(MAX_PAGES)) u_store (
    .clk, .rst, .op, .cols, .pages, .rd_req(st == T_RD), .rd_idx(ridx),
    .rd_data(rdat), .clr_busy
  );
endmodule
`default_nettype wire

// ===== rtl/pfde_store.sv =====
`default_nettype none
// Frame memory with one read-modify-write per cycle; a write still in
// flight is forwarded to the next read of the same byte.
module pfde_store #(
  parameter int MAX_WIDTH = pfde_pkg::MAX_WIDTH_DEF,
  parameter int MAX_PAGES = pfde_pkg::MAX_PAGES_DEF,
  localparam int DEPTH = MAX_WIDTH * MAX_PAGES,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pfde_pkg::pix_op_t op,
  input  wire logic [8:0]        cols,
  input  wire logic [5:0]        pages,
  input  wire logic              rd_req,
  input  wire logic [9:0]        rd_idx,
  output logic [7:0]             rd_data,
  output logic                   clr_busy
);
  logic [7:0] mem [DEPTH];
  logic [AW:0] clr_cnt;
  // stage 1 registers
  logic          s1_valid, s1_byte, s1_on;
  logic [AW-1:0] s1_addr;
  logic [7:0]    s1_mask, s1_fill;
  logic [7:0]    q;
  // last write for forwarding
  logic          w_valid;
  logic [AW-1:0] w_addr;
  logic [7:0]    w_data;

  logic          hit;
  logic [AW-1:0] addr;
  logic [15:0]   prod;
  logic [7:0]    cur, nv;

  assign clr_busy = !clr_cnt[AW];

  // address and clipping
  always_comb begin
    prod = 16'(cols) * 16'(op.y[10:3]);
    addr = op.wr_byte ? AW'(op.idx) : AW'(prod + 16'(op.x));
    hit = op.valid;
    if (!op.wr_byte) begin
      if (op.x[10] || op.y[10]) hit = 1'b0;
      else if ({2'b0, op.x} >= 13'(cols)) hit = 1'b0;
      else if ({2'b0, op.y} >= {4'b0, pages, 3'b0}) hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      s1_valid <= 1'b0;
      w_valid <= 1'b0;
    end else begin
      s1_valid <= hit && !clr_busy;
      w_valid <= 1'b0;
      if (clr_busy) begin
        clr_cnt <= clr_cnt + 1'b1;
      end else if (s1_valid) begin
        w_valid <= 1'b1;
      end
    end
    s1_byte <= op.wr_byte;
    s1_on <= op.on;
    s1_fill <= op.fill;
    s1_addr <= rd_req ? AW'(rd_idx) : addr;
    s1_mask <= 8'(1) << op.y[2:0];
    q <= mem[rd_req ? AW'(rd_idx) : addr];
    if (clr_busy) mem[clr_cnt[AW-1:0]] <= 8'h00;
    else if (s1_valid) mem[s1_addr] <= nv;
    w_addr <= s1_addr;
    w_data <= nv;
  end

  // modify
  always_comb begin
    cur = (w_valid && w_addr == s1_addr) ? w_data : q;
    if (s1_byte) nv = s1_fill;
    else if (s1_on) nv = cur | s1_mask;
    else nv = cur & ~s1_mask;
  end

  assign rd_data = cur;
endmodule
`default_nettype wire

// ===== rtl/pfde_seq.sv =====
`default_nettype none
// Action sequencer: walks the pixels (or erase bytes) of one action, one per cycle outside line setup and hold steps.
// Line steps keep y = ly + floor(dy*k/dx) with an exact remainder.
module pfde_seq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [2:0]        action,
  input  wire logic signed [8:0] x_a,
  input  wire logic signed [8:0] y_a,
  input  wire logic signed [8:0] x_b,
  input  wire logic signed [8:0] y_b,
  input  wire logic              pixel_value,
  input  wire logic [63:0]       pattern,
  input  wire logic [15:0]       used,
  output pfde_pkg::pix_op_t      op,
  output logic                   busy
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ERASE = 6'b000010,
    S_RECT  = 6'b000100,
    S_BLIT  = 6'b001000,
    S_LSET  = 6'b010000,
    S_LINE  = 6'b100000
  } st_t;
  st_t st;
  logic              on;
  logic [15:0]       cnt;          // erase index
  logic [7:0]        x0, y0, w, h, i, j;
  logic [63:0]       pat;
  // line registers
  logic signed [10:0] lx1, ly1, lx2, ly2;
  logic signed [10:0] cx, cy, dx, dy, ex, rem;
  logic              vert;
  logic              hold;         // steep catch-up cycle, no pixel
  logic [1:0]        seg;
  logic              outl;
  logic signed [10:0] ox1, oy1, oxa, oya;

  always_comb begin
    op = '0;
    op.on = on;
    op.fill = on ? 8'hFF : 8'h00;
    unique case (st)
      S_ERASE: begin
        op.valid = 1'b1; op.wr_byte = 1'b1; op.idx = cnt;
      end
      S_RECT: begin
        op.valid = 1'b1;
        op.x = {3'b0, 8'(x0 + i)};
        op.y = {3'b0, 8'(y0 + j)};
      end
      S_BLIT: begin
        op.valid = pat[6'(63 - {i[2:0], 3'b0} - j[2:0])];
        op.on = 1'b1;
        op.x = {3'b0, 8'(x0 + {5'b0, j[2:0]})};
        op.y = {3'b0, 8'(y0 + {5'b0, i[2:0]})};
      end
      S_LINE: begin
        op.valid = !hold; op.on = 1'b1; op.x = cx; op.y = cy;
      end
      default: ;
    endcase
  end

  assign busy = (st != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      unique case (st)
        S_IDLE: if (start) begin
          on <= pixel_value;
          pat <= pattern;
          x0 <= 8'(x_a); y0 <= 8'(y_a); w <= 8'(x_b); h <= 8'(y_b);
          i <= '0; j <= '0; cnt <= '0;
          outl <= 1'b0; seg <= '0;
          case (action)
            pfde_pkg::ACT_ERASE:
              if (used != 16'd0) st <= S_ERASE;
            pfde_pkg::ACT_PIXEL: begin
              // a pixel is a fill of one
              w <= 8'd1; h <= 8'd1; st <= S_RECT;
              x0 <= 8'(x_a); y0 <= 8'(y_a);
              if (x_a < 0 || y_a < 0) st <= S_IDLE;
            end
            pfde_pkg::ACT_FILL:
              if (8'(x_b) != 0 && 8'(y_b) != 0) st <= S_RECT;
            pfde_pkg::ACT_BLIT: st <= S_BLIT;
            pfde_pkg::ACT_LINE: begin
              lx1 <= 11'(x_a); ly1 <= 11'(y_a); lx2 <= 11'(x_b); ly2 <= 11'(y_b);
              st <= S_LSET;
            end
            pfde_pkg::ACT_OUTL: begin
              outl <= 1'b1;
              oxa <= 11'(x_a); oya <= 11'(y_a);
              ox1 <= 11'(x_a) + 11'(x_b); oy1 <= 11'(y_a) + 11'(y_b);
              lx1 <= 11'(x_a); ly1 <= 11'(y_a);
              lx2 <= 11'(x_a) + 11'(x_b); ly2 <= 11'(y_a);
              st <= S_LSET;
            end
            default: ;
          endcase
        end
        S_ERASE: begin
          cnt <= cnt + 1'b1;
          if (cnt == used - 16'd1) st <= S_IDLE;
        end
        S_RECT: begin
          if (j == h - 8'd1) begin
            j <= '0;
            if (i == w - 8'd1) st <= S_IDLE;
            i <= i + 1'b1;
          end else j <= j + 1'b1;
        end
        S_BLIT: begin
          j <= j + 1'b1;
          if (j == 8'd7) begin
            j <= '0; i <= i + 1'b1;
            if (i == 8'd7) st <= S_IDLE;
          end
        end
        S_LSET: begin
          vert <= (lx1 == lx2);
          if (lx1 == lx2) begin
            cx <= lx1;
            cy <= (ly1 < ly2) ? ly1 : ly2;
            ex <= (ly1 < ly2) ? ly2 : ly1;
          end else if (lx1 < lx2) begin
            cx <= lx1; cy <= ly1; dx <= lx2 - lx1; dy <= ly2 - ly1; ex <= lx2;
          end else begin
            cx <= lx2; cy <= ly2; dx <= lx1 - lx2; dy <= ly1 - ly2; ex <= lx1;
          end
          rem <= '0;
          hold <= 1'b0;
          st <= S_LINE;
        end
        S_LINE: begin
          if (vert) begin
            cy <= cy + 11'sd1;
          end else begin
            // rem is back in [0,dx) after each pixel step; add dy and renormalize, |dy| can exceed dx
            cx <= cx + 11'sd1;
          end
          if ((vert && cy == ex) || (!vert && cx == ex)) begin
            if (outl && seg != 2'd3) begin
              seg <= seg + 1'b1;
              st <= S_LSET;
              unique case (seg)
                2'd0: begin lx1 <= oxa; ly1 <= oy1; lx2 <= ox1; ly2 <= oy1; end
                2'd1: begin lx1 <= oxa; ly1 <= oya; lx2 <= oxa; ly2 <= oy1; end
                default: begin lx1 <= ox1; ly1 <= oya; lx2 <= ox1; ly2 <= oy1; end
              endcase
            end else st <= S_IDLE;
          end else if (!vert) begin
            st <= S_LINE;
          end
        end
        default: st <= S_IDLE;
      endcase
      // non-vertical step: advance y by floor of accumulated dy/dx
      if (st == S_LINE && !vert) begin
        hold <= 1'b0;
        if (rem + dy >= dx) begin
          // large slopes take extra hold steps: hold x and step y, no pixel
          if (rem + dy - dx >= dx || rem + dy - dx < 0) begin
            cx <= cx; rem <= rem - dx; cy <= cy + 11'sd1; hold <= 1'b1;
            if (!((cx == ex))) st <= S_LINE;
          end else begin
            rem <= rem + dy - dx; cy <= cy + 11'sd1;
          end
        end else if (rem + dy < 0) begin
          if (rem + dy + dx < 0) begin
            cx <= cx; rem <= rem + dx; cy <= cy - 11'sd1; hold <= 1'b1;
            if (!((cx == ex))) st <= S_LINE;
          end else begin
            rem <= rem + dy + dx; cy <= cy - 11'sd1;
          end
        end else begin
          rem <= rem + dy;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/pfde_check.sv =====
`default_nettype none
module pfde_check (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic [7:0] read_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data))
    else $error("stalled result changed");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second action taken while busy");
  a_outbusy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken with result pending");
endmodule
bind page_framebuffer_draw_engine pfde_check u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .read_data
);
`default_nettype wire
